### rtl/bpi_pkg.sv
// shared types and constants for the bicubic pixel interpolator
// no dependencies; compiled before the interface and all modules
package bpi_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int PIX_W         = 8;
    localparam int FRAC_W        = 8;
    localparam int ROW_W         = 32;
    localparam int PIX_PER_ROW   = 4;
    localparam int NUM_ROWS      = 4;
    localparam int CUBIC_STAGES  = 5;
    localparam logic [PIX_W-1:0] GRAY_MAX = 8'hFF;

    // input request: 4x4 neighbourhood plus fractional offsets
    typedef struct packed {
        logic [ROW_W-1:0]  row_0;
        logic [ROW_W-1:0]  row_1;
        logic [ROW_W-1:0]  row_2;
        logic [ROW_W-1:0]  row_3;
        logic [FRAC_W-1:0] frac_x;
        logic [FRAC_W-1:0] frac_y;
    } t_pix_req;

    // output response: one gray pixel
    typedef struct packed {
        logic [PIX_W-1:0] gray_out;
    } t_pix_rsp;

    // per-stage advance strobes for one cubic lane
    typedef struct packed {
        logic [CUBIC_STAGES-1:0] adv;
    } t_lane_ctl;

endpackage

### rtl/bpi_stream_if.sv
// valid/ready stream channel carrying one payload of type T
// depends on nothing; payload types come from bpi_pkg
interface bpi_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/bpi_cubic_lane.sv
// one catmull-rom cubic lane: coefficients, then three horner steps, then halving
// depends on bpi_pkg for the lane control struct and stage count
module bpi_cubic_lane #(
    parameter int FRAC_BITS = bpi_pkg::FRAC_BITS_DEF,
    parameter int W_IN      = FRAC_BITS + 9,
    parameter int W_ACC     = FRAC_BITS + 14
) (
    input  logic                          i_clk,
    input  bpi_pkg::t_lane_ctl            i_ctl,
    input  logic signed [W_IN-1:0]        i_p0,
    input  logic signed [W_IN-1:0]        i_p1,
    input  logic signed [W_IN-1:0]        i_p2,
    input  logic signed [W_IN-1:0]        i_p3,
    input  logic [bpi_pkg::FRAC_W-1:0]    i_t,
    output logic signed [W_ACC-1:0]       o_res
);

    localparam int W_PROD = W_ACC + bpi_pkg::FRAC_W + 1;

    logic signed [W_ACC-1:0] e0, e1, e2, e3;
    logic signed [W_ACC-1:0] n_a2, n_b2, n_c2;

    // stage 1 registers: doubled coefficients
    logic signed [W_ACC-1:0]       r_a2, r_b2_1, r_c2_1, r_p1_1;
    logic [bpi_pkg::FRAC_W-1:0]    r_t_1;
    // stage 2
    logic signed [W_PROD-1:0]      r_m1;
    logic signed [W_ACC-1:0]       r_b2_2, r_c2_2, r_p1_2;
    logic [bpi_pkg::FRAC_W-1:0]    r_t_2;
    // stage 3
    logic signed [W_PROD-1:0]      r_m2;
    logic signed [W_ACC-1:0]       r_c2_3, r_p1_3;
    logic [bpi_pkg::FRAC_W-1:0]    r_t_3;
    // stage 4
    logic signed [W_PROD-1:0]      r_m3;
    logic signed [W_ACC-1:0]       r_p1_4;
    // stage 5
    logic signed [W_ACC-1:0]       r_res;

    logic signed [W_PROD-1:0] sh1, sh2, sh3;
    logic signed [W_ACC-1:0]  n_acc1, n_acc2, n_acc3;
    logic signed [W_PROD-1:0] n_m1, n_m2, n_m3;
    logic signed [W_ACC-1:0]  n_res;

    // sign extension of the four samples
    assign e0 = {{(W_ACC-W_IN){i_p0[W_IN-1]}}, i_p0};
    assign e1 = {{(W_ACC-W_IN){i_p1[W_IN-1]}}, i_p1};
    assign e2 = {{(W_ACC-W_IN){i_p2[W_IN-1]}}, i_p2};
    assign e3 = {{(W_ACC-W_IN){i_p3[W_IN-1]}}, i_p3};

    // doubled cubic coefficients
    assign n_a2 = W_ACC'(-e0 + 3 * e1 - 3 * e2 + e3);
    assign n_b2 = W_ACC'(2 * e0 - 5 * e1 + 4 * e2 - e3);
    assign n_c2 = e2 - e0;

    // horner steps, floor shift is an arithmetic shift
    assign n_m1   = r_a2 * $signed({1'b0, r_t_1});
    assign sh1    = r_m1 >>> FRAC_BITS;
    assign n_acc1 = r_b2_2 + sh1[W_ACC-1:0];
    assign n_m2   = n_acc1 * $signed({1'b0, r_t_2});
    assign sh2    = r_m2 >>> FRAC_BITS;
    assign n_acc2 = r_c2_3 + sh2[W_ACC-1:0];
    assign n_m3   = n_acc2 * $signed({1'b0, r_t_3});
    assign sh3    = r_m3 >>> FRAC_BITS;
    assign n_acc3 = {r_p1_4[W_ACC-2:0], 1'b0} + sh3[W_ACC-1:0];
    assign n_res  = n_acc3 >>> 1;

    // stage 1
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[0]) begin
            r_a2   <= n_a2;
            r_b2_1 <= n_b2;
            r_c2_1 <= n_c2;
            r_p1_1 <= e1;
            r_t_1  <= i_t;
        end
    end

    // stage 2: first product
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[1]) begin
            r_m1   <= n_m1;
            r_b2_2 <= r_b2_1;
            r_c2_2 <= r_c2_1;
            r_p1_2 <= r_p1_1;
            r_t_2  <= r_t_1;
        end
    end

    // stage 3: second product
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[2]) begin
            r_m2   <= n_m2;
            r_c2_3 <= r_c2_2;
            r_p1_3 <= r_p1_2;
            r_t_3  <= r_t_2;
        end
    end

    // stage 4: third product
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[3]) begin
            r_m3   <= n_m3;
            r_p1_4 <= r_p1_3;
        end
    end

    // stage 5: add constant term and halve
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[4]) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

### rtl/bpi_merge.sv
// merging stage: vertical cubic over the four row results, then clamp to 0..255
// depends on bpi_pkg and bpi_cubic_lane
module bpi_merge #(
    parameter int FRAC_BITS = bpi_pkg::FRAC_BITS_DEF,
    parameter int W_ROW     = FRAC_BITS + 14,
    parameter int W_COL     = FRAC_BITS + 18
) (
    input  logic                        i_clk,
    input  bpi_pkg::t_lane_ctl          i_ctl,
    input  logic                        i_adv_out,
    input  logic signed [W_ROW-1:0]     i_r0,
    input  logic signed [W_ROW-1:0]     i_r1,
    input  logic signed [W_ROW-1:0]     i_r2,
    input  logic signed [W_ROW-1:0]     i_r3,
    input  logic [bpi_pkg::FRAC_W-1:0]  i_t,
    output logic [bpi_pkg::PIX_W-1:0]   o_gray
);

    logic signed [W_COL-1:0]      col_res;
    logic signed [W_COL-1:0]      col_int;
    logic [bpi_pkg::PIX_W-1:0]    n_gray;
    logic [bpi_pkg::PIX_W-1:0]    r_gray;

    // vertical interpolation lane
    bpi_cubic_lane #(
        .FRAC_BITS (FRAC_BITS),
        .W_IN      (W_ROW),
        .W_ACC     (W_COL)
    ) u_col (
        .i_clk (i_clk),
        .i_ctl (i_ctl),
        .i_p0  (i_r0),
        .i_p1  (i_r1),
        .i_p2  (i_r2),
        .i_p3  (i_r3),
        .i_t   (i_t),
        .o_res (col_res)
    );

    // drop fraction bits and clamp
    assign col_int = col_res >>> FRAC_BITS;

    always_comb begin
        if (col_int[W_COL-1]) begin
            n_gray = '0;
        end else if (|col_int[W_COL-2:bpi_pkg::PIX_W]) begin
            n_gray = bpi_pkg::GRAY_MAX;
        end else begin
            n_gray = col_int[bpi_pkg::PIX_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_adv_out) begin
            r_gray <= n_gray;
        end
    end

    assign o_gray = r_gray;

endmodule

### rtl/bicubic_pixel_interpolator.sv
// bicubic (catmull-rom) gray pixel interpolator, four row lanes plus a column merge
// pipeline: 11 register stages (5 per cubic lane + 1 clamp)
// throughput: one request per cycle unless the output stalls; each pipeline stage holds
// one request and advances whenever the stage after it is empty or moving, so bubbles collapse
// reset: i_rst_n (synchronous) clears only the stage valid bits, datapath is not reset
module bicubic_pixel_interpolator #(
    parameter int FRAC_BITS = bpi_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bpi_stream_if.sink    i_pix,
    bpi_stream_if.source  o_pix
);

    localparam int NSTG  = 2 * bpi_pkg::CUBIC_STAGES + 1;
    localparam int W_PIX = FRAC_BITS + bpi_pkg::PIX_W + 1;
    localparam int W_ROW = FRAC_BITS + 14;
    localparam int W_COL = FRAC_BITS + 18;
    localparam logic [bpi_pkg::FRAC_W-1:0] T_MASK =
        (FRAC_BITS >= bpi_pkg::FRAC_W) ? {bpi_pkg::FRAC_W{1'b1}}
                                       : bpi_pkg::FRAC_W'((1 << FRAC_BITS) - 1);

    logic [NSTG-1:0]                r_vld;
    logic [NSTG-1:0]                adv;
    bpi_pkg::t_lane_ctl             row_ctl;
    bpi_pkg::t_lane_ctl             col_ctl;
    logic [bpi_pkg::FRAC_W-1:0]     tx;
    logic [bpi_pkg::FRAC_W-1:0]     r_ty [bpi_pkg::CUBIC_STAGES];
    logic [bpi_pkg::ROW_W-1:0]      rows [bpi_pkg::NUM_ROWS];
    logic signed [W_ROW-1:0]        row_res [bpi_pkg::NUM_ROWS];
    logic [bpi_pkg::PIX_W-1:0]      gray;

    // stage advance chain from the output back to the input
    always_comb begin
        adv[NSTG-1] = ~r_vld[NSTG-1] | o_pix.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = ~r_vld[k] | adv[k+1];
        end
    end

    assign row_ctl.adv = adv[bpi_pkg::CUBIC_STAGES-1:0];
    assign col_ctl.adv = adv[2*bpi_pkg::CUBIC_STAGES-1:bpi_pkg::CUBIC_STAGES];

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // vertical offset travels beside the row lanes
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_ty[0] <= i_pix.data.frac_y & T_MASK;
        end
        for (int k = 1; k < bpi_pkg::CUBIC_STAGES; k++) begin
            if (adv[k]) begin
                r_ty[k] <= r_ty[k-1];
            end
        end
    end

    assign tx      = i_pix.data.frac_x & T_MASK;
    assign rows[0] = i_pix.data.row_0;
    assign rows[1] = i_pix.data.row_1;
    assign rows[2] = i_pix.data.row_2;
    assign rows[3] = i_pix.data.row_3;

    // horizontal interpolation lanes, one per neighbourhood row
    for (genvar r = 0; r < bpi_pkg::NUM_ROWS; r++) begin : g_row
        logic signed [W_PIX-1:0] px [bpi_pkg::PIX_PER_ROW];

        for (genvar k = 0; k < bpi_pkg::PIX_PER_ROW; k++) begin : g_px
            assign px[k] = $signed({1'b0,
                                    rows[r][bpi_pkg::PIX_W*k +: bpi_pkg::PIX_W],
                                    {FRAC_BITS{1'b0}}});
        end

        bpi_cubic_lane #(
            .FRAC_BITS (FRAC_BITS),
            .W_IN      (W_PIX),
            .W_ACC     (W_ROW)
        ) u_lane (
            .i_clk (i_clk),
            .i_ctl (row_ctl),
            .i_p0  (px[0]),
            .i_p1  (px[1]),
            .i_p2  (px[2]),
            .i_p3  (px[3]),
            .i_t   (tx),
            .o_res (row_res[r])
        );
    end

    // column merge and clamp
    bpi_merge #(
        .FRAC_BITS (FRAC_BITS),
        .W_ROW     (W_ROW),
        .W_COL     (W_COL)
    ) u_merge (
        .i_clk     (i_clk),
        .i_ctl     (col_ctl),
        .i_adv_out (adv[NSTG-1]),
        .i_r0      (row_res[0]),
        .i_r1      (row_res[1]),
        .i_r2      (row_res[2]),
        .i_r3      (row_res[3]),
        .i_t       (r_ty[bpi_pkg::CUBIC_STAGES-1]),
        .o_gray    (gray)
    );

    // channel handshakes
    assign i_pix.ready         = adv[0];
    assign o_pix.valid         = r_vld[NSTG-1];
    assign o_pix.data.gray_out = gray;

endmodule
